// File: design/lru_key_tracker_core_defines.svh
// Assertion macros used by the checker file.
`ifndef LRU_KEY_TRACKER_CORE_DEFINES_SVH
`define LRU_KEY_TRACKER_CORE_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define LKT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Check a property on every rising edge, reset included.
`define LKT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// File: design/lkt_pkg.sv
package lkt_pkg;

  localparam int KEY_W       = 32;
  localparam int CAP_W       = 5;
  localparam int OCC_W       = 5;
  localparam int DEF_ENTRIES = 16;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;
  localparam int OUT_DW      = 40;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Command codes carried in in_tuser.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_ACCESS = 1'b1;

  // Register index, taken from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_GO,
    ST_SRCH_WAIT,
    ST_SHFT_GO,
    ST_SHFT_WAIT,
    ST_WRITE
  } state_t;

  // Token that walks down the cell chain.
  typedef struct packed {
    logic             vld;
    logic             shift;  // 0: search walk, 1: shift walk
    logic             done;   // stopped at a matching or final cell
    logic [KEY_W-1:0] carry;  // key handed to the next cell
  } tok_t;

endpackage

// File: design/lkt_cell.sv
module lkt_cell #(
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lkt_pkg::tok_t            tok_i,
  input  logic [lkt_pkg::KEY_W-1:0] key_i,
  input  logic [CNT_W-1:0]         count_i,
  input  logic                     grow_i,
  output lkt_pkg::tok_t            tok_o
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [lkt_pkg::KEY_W-1:0] key_r;
  logic [lkt_pkg::KEY_W-1:0] key_nxt;
  lkt_pkg::tok_t             tok_r;
  lkt_pkg::tok_t             tok_nxt;
  logic                      in_range;
  logic                      match;

  assign in_range = IDX_C < count_i;
  assign match    = key_r == key_i;

  always_comb begin
    tok_nxt = tok_i;
    key_nxt = key_r;
    if (tok_i.vld && !tok_i.done) begin
      if (in_range) begin
        // swap own key with the carried one while shifting
        if (tok_i.shift) begin
          key_nxt       = tok_i.carry;
          tok_nxt.carry = key_r;
        end
        if (match) begin
          tok_nxt.done = 1'b1;
        end
      end else if (IDX_C == count_i && tok_i.shift) begin
        // first free cell: take the key when the list grows
        if (grow_i) begin
          key_nxt = tok_i.carry;
        end
        tok_nxt.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// File: design/lru_key_tracker_core.sv
// Channel  | Dir | Ports             | Contents
// in_      | in  | tvalid/tready     | tdata: key[31:0]; tuser: command (0 insert, 1 access)
// out_     | out | tvalid/tready     | tdata: hit[0], evicted_key[32:1], occupancy[37:33],
//          |     |                   |   zero[39:38]; tuser: evicted_valid
// cfg_     | in  | APB, pready = 1   | 0x0: capacity[4:0]
//
// One word is in flight at a time. A search token walks the ENTRIES-cell
// chain one cell per cycle, then a shift token walks it again on a hit or
// an insert miss; an insert while capacity is zero skips both walks. Reset
// (rst_n low, synchronous) empties the list and sets capacity to 16. A
// result waits in the output register; the next word is taken meanwhile
// and holds in ST_WRITE.
module lru_key_tracker_core #(
  parameter int ENTRIES = lkt_pkg::DEF_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lkt_pkg::KEY_W-1:0]     in_tdata,   // key[31:0]
  input  logic                          in_tuser,   // command
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lkt_pkg::OUT_DW-1:0]    out_tdata,  // hit, evicted_key, occupancy, pad
  output logic                          out_tuser,  // evicted_valid
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lkt_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [lkt_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [lkt_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int EXT_W = (CNT_W > lkt_pkg::CAP_W) ? CNT_W : lkt_pkg::CAP_W;
  localparam logic [EXT_W-1:0] ENTRIES_C = EXT_W'(ENTRIES);

  lkt_pkg::state_t state_r, state_nxt;

  logic                        cmd_r, cmd_nxt;
  logic [lkt_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [lkt_pkg::CAP_W-1:0]   capacity_r;
  logic                        hit_r, hit_nxt;
  logic                        grow_r, grow_nxt;
  logic                        ev_valid_r, ev_valid_nxt;
  logic [lkt_pkg::KEY_W-1:0]   ev_key_r, ev_key_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_hit_r, out_hit_nxt;
  logic                        out_ev_valid_r, out_ev_valid_nxt;
  logic [lkt_pkg::KEY_W-1:0]   out_ev_key_r, out_ev_key_nxt;
  logic [lkt_pkg::OCC_W-1:0]   out_occ_r, out_occ_nxt;

  logic [EXT_W-1:0]            cap_ext;
  logic [EXT_W-1:0]            cap_sat;
  logic [EXT_W-1:0]            count_ext;
  logic                        cap_zero;
  logic                        cfg_wr;

  lkt_pkg::tok_t               inject;
  lkt_pkg::tok_t               tok_w [0:ENTRIES];
  lkt_pkg::tok_t               chain_out;

  // ---------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= lkt_pkg::CAP_RESET;
    end else if (cfg_wr && cfg_paddr[2] == lkt_pkg::REG_CAPACITY) begin
      capacity_r <= cfg_pwdata[lkt_pkg::CAP_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == lkt_pkg::REG_CAPACITY)
                    ? {{(lkt_pkg::CFG_DW - lkt_pkg::CAP_W){1'b0}}, capacity_r}
                    : '0;

  // Saturate capacity to the chain length.
  assign cap_ext   = EXT_W'(capacity_r);
  assign cap_sat   = (cap_ext > ENTRIES_C) ? ENTRIES_C : cap_ext;
  assign count_ext = EXT_W'(count_r);
  assign cap_zero  = capacity_r == '0;

  // ---------------------------------------------------------------
  // Cell chain: slot 0 most recent
  // ---------------------------------------------------------------
  assign tok_w[0]  = inject;
  assign chain_out = tok_w[ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkt_cell #(
      .CNT_W (CNT_W),
      .IDX   (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_i   (tok_w[g]),
      .key_i   (key_r),
      .count_i (count_r),
      .grow_i  (grow_r),
      .tok_o   (tok_w[g+1])
    );
  end

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  always_comb begin
    state_nxt        = state_r;
    cmd_nxt          = cmd_r;
    key_nxt          = key_r;
    count_nxt        = count_r;
    hit_nxt          = hit_r;
    grow_nxt         = grow_r;
    ev_valid_nxt     = ev_valid_r;
    ev_key_nxt       = ev_key_r;
    out_valid_nxt    = out_valid_r;
    out_hit_nxt      = out_hit_r;
    out_ev_valid_nxt = out_ev_valid_r;
    out_ev_key_nxt   = out_ev_key_r;
    out_occ_nxt      = out_occ_r;
    inject           = '0;
    in_tready        = 1'b0;

    // drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      lkt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt      = in_tuser;
          key_nxt      = in_tdata;
          hit_nxt      = 1'b0;
          ev_valid_nxt = 1'b0;
          ev_key_nxt   = '0;
          // insert with capacity zero changes nothing
          if (in_tuser == lkt_pkg::CMD_INSERT && cap_zero) begin
            state_nxt = lkt_pkg::ST_WRITE;
          end else begin
            state_nxt = lkt_pkg::ST_SRCH_GO;
          end
        end
      end
      lkt_pkg::ST_SRCH_GO: begin
        inject.vld   = 1'b1;
        inject.shift = 1'b0;
        state_nxt    = lkt_pkg::ST_SRCH_WAIT;
      end
      lkt_pkg::ST_SRCH_WAIT: begin
        if (chain_out.vld) begin
          hit_nxt  = chain_out.done;
          grow_nxt = count_ext < cap_sat;
          // promote on a hit; an insert miss shifts the new key in
          if (chain_out.done || cmd_r == lkt_pkg::CMD_INSERT) begin
            state_nxt = lkt_pkg::ST_SHFT_GO;
          end else begin
            state_nxt = lkt_pkg::ST_WRITE;
          end
        end
      end
      lkt_pkg::ST_SHFT_GO: begin
        inject.vld   = 1'b1;
        inject.shift = 1'b1;
        inject.carry = key_r;
        state_nxt    = lkt_pkg::ST_SHFT_WAIT;
      end
      lkt_pkg::ST_SHFT_WAIT: begin
        if (chain_out.vld) begin
          if (!hit_r) begin
            if (grow_r) begin
              count_nxt = count_r + CNT_W'(1);
            end else begin
              // the least recent key falls off the end of the list
              ev_valid_nxt = 1'b1;
              ev_key_nxt   = chain_out.carry;
            end
          end
          state_nxt = lkt_pkg::ST_WRITE;
        end
      end
      lkt_pkg::ST_WRITE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt    = 1'b1;
          out_hit_nxt      = hit_r;
          out_ev_valid_nxt = ev_valid_r;
          out_ev_key_nxt   = ev_key_r;
          out_occ_nxt      = count_ext[lkt_pkg::OCC_W-1:0];
          state_nxt        = lkt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lkt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lkt_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    cmd_r          <= cmd_nxt;
    key_r          <= key_nxt;
    hit_r          <= hit_nxt;
    grow_r         <= grow_nxt;
    ev_valid_r     <= ev_valid_nxt;
    ev_key_r       <= ev_key_nxt;
    out_hit_r      <= out_hit_nxt;
    out_ev_valid_r <= out_ev_valid_nxt;
    out_ev_key_r   <= out_ev_key_nxt;
    out_occ_r      <= out_occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_valid_r;
  assign out_tdata  = {2'b00, out_occ_r, out_ev_key_r, out_hit_r};

endmodule

// File: design/lkt_checker.sv
`include "lru_key_tracker_core_defines.svh"

module lkt_checker #(
  parameter int ENTRIES = lkt_pkg::DEF_ENTRIES
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [lkt_pkg::OUT_DW-1:0] out_tdata,
  input logic                       out_tuser
);

  // no result right after reset
  `LKT_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid)

  // a stalled word holds
  `LKT_ASSERT(a_hold, clk, rst_n,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // evicted key reads zero unless an eviction happened
  `LKT_ASSERT(a_ev_zero, clk, rst_n, out_tvalid && !out_tuser |-> out_tdata[32:1] == '0)

  // an eviction only follows a miss, and the list never outgrows the chain
  `LKT_ASSERT(a_ev_miss, clk, rst_n, out_tvalid && out_tuser |-> !out_tdata[0])
  `LKT_ASSERT(a_occ_max, clk, rst_n,
    out_tvalid |-> (ENTRIES > 31) || (out_tdata[37:33] <= ENTRIES))

endmodule

bind lru_key_tracker_core lkt_checker #(
  .ENTRIES (ENTRIES)
) u_lkt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
